>>> sv/dilated_spectral_difference_core_assert.svh
// Assertion macros used by the checker file.
`ifndef DILATED_SPECTRAL_DIFFERENCE_CORE_ASSERT_SVH
`define DILATED_SPECTRAL_DIFFERENCE_CORE_ASSERT_SVH

// Implication in the same cycle, quiet while reset is held.
`define DSD_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Implication in the next cycle, quiet while reset is held.
`define DSD_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// Implication in the next cycle, checked during reset as well.
`define DSD_ASSERT_NXT_RST(label, clk, pre, post, msg) \
  label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

>>> sv/dsd_pkg.sv
// Shared constants, types and helpers of the spectral difference core.
`timescale 1ns / 1ps
package dsd_pkg;

  localparam int MAX_BANDS   = 256;
  localparam int MAX_LAG     = 8;
  localparam int SAMPLE_BITS = 16;

  localparam int HW_W   = 7;
  localparam int LAGC_W = 4;
  localparam int BCC_W  = 9;
  localparam int CFG_W  = 9;
  localparam int IDX_W  = 2;

  localparam int NSLOT  = MAX_LAG + 1;
  localparam int SLOT_W = $clog2(NSLOT);
  localparam int LAG_W  = $clog2(MAX_LAG + 1);
  localparam int BIN_W  = $clog2(MAX_BANDS);
  localparam int CNT_W  = $clog2(MAX_BANDS + 1);
  localparam int DEPTH  = NSLOT * MAX_BANDS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = CNT_W + SAMPLE_BITS + 1;
  localparam int OUT_W  = SAMPLE_BITS + 1;
  localparam int IN_TW  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  localparam logic [IDX_W-1:0] CFG_HALF_WINDOW = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FRAME_LAG   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_BAND_COUNT  = 2'd2;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_WIN,
    ST_SUM,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;    // clear running maximum
    logic step;   // fold sample into maximum, shift samples down
    logic shift;  // shift maxima down towards cell 0
  } cell_ctl_t;

  function automatic sample_t smax(input sample_t a, input sample_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> sv/dilated_spectral_difference_core.sv
// Path: a frame-end sample's result comes from the window walk along the cell row, the
//   lagged-frame read stream and the bit-serial divider; warming frames and frames with
//   no inner bins skip the walk. Throughput: one band sample a cycle within a frame, but
//   none during the walk or at a frame end while the previous result is still pending.
// Reset (synchronous, rst_n low): registers to their defaults, counters and slot cleared;
//   sample stores hold undefined data until written.
`timescale 1ns / 1ps
module dilated_spectral_difference_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dsd_pkg::IN_TW-1:0]      in_tdata,   // [15:0] band_sample
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dsd_pkg::OUT_TW-1:0]     out_tdata,  // [16:0] frame_mean_diff
  output logic [0:0]                     out_tuser,  // [0] warming
  input  logic                           cfg_wen,
  input  logic [dsd_pkg::IDX_W-1:0]      cfg_index,
  input  logic [dsd_pkg::CFG_W-1:0]      cfg_wdata
);
  import dsd_pkg::*;

  // configuration registers
  logic [HW_W-1:0]   half_window_r;
  logic [LAGC_W-1:0] frame_lag_r;
  logic [BCC_W-1:0]  band_count_r;

  // frame bookkeeping
  logic [BIN_W-1:0]  bin_r;
  logic [LAG_W-1:0]  frames_seen_r;
  logic [SLOT_W-1:0] wslot_r;

  // frame-end walk
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [SLOT_W-1:0] ref_slot_r;
  logic [HW_W-1:0]   hw_r;
  logic [CNT_W-1:0]  inner_r;
  logic              warm_r;
  logic              pvld_r;
  sample_t           m_d_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [OUT_W-1:0] res_r;

  // output register
  logic              out_vld_r;
  logic signed [OUT_W-1:0] out_diff_r;
  logic              out_warm_r;

  logic [BIN_W:0]    bc_eff;
  logic [LAG_W-1:0]  lag_eff;
  logic              last_sample, in_acc, out_acc;
  logic [31:0]       two_hw;
  logic              no_inner;
  logic [SLOT_W-1:0] ref_slot;
  cell_ctl_t         ctl;
  logic              div_start, div_done;
  logic signed [OUT_W-1:0] div_q;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  sample_t           rd_data;
  logic [CNT_W-1:0]  win_len;

  sample_t s_q [MAX_BANDS];
  sample_t m_q [MAX_BANDS];

  // band count: zero acts as one, large values clamp
  always_comb begin
    if (band_count_r == '0) begin
      bc_eff = (BIN_W + 1)'(1);
    end else if (32'(band_count_r) > 32'(MAX_BANDS)) begin
      bc_eff = (BIN_W + 1)'(MAX_BANDS);
    end else begin
      bc_eff = (BIN_W + 1)'(band_count_r);
    end
    lag_eff = (32'(frame_lag_r) > 32'(MAX_LAG)) ? LAG_W'(MAX_LAG) : LAG_W'(frame_lag_r);
  end

  assign last_sample = (32'(bin_r) + 32'd1) >= 32'(bc_eff);
  assign two_hw      = 32'(half_window_r) << 1;
  assign no_inner    = two_hw >= 32'(bc_eff);
  assign ref_slot    = (32'(wslot_r) >= 32'(lag_eff))
                       ? SLOT_W'(32'(wslot_r) - 32'(lag_eff))
                       : SLOT_W'(32'(wslot_r) + 32'(NSLOT) - 32'(lag_eff));
  assign win_len     = CNT_W'({hw_r, 1'b0});

  // a frame-end sample waits while the previous result is still pending
  assign in_tready = (state_r == ST_IDLE) && !(out_vld_r && last_sample);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_vld_r && out_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_window_r <= HW_W'(1);
      frame_lag_r   <= LAGC_W'(1);
      band_count_r  <= BCC_W'(256);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_HALF_WINDOW: half_window_r <= cfg_wdata[HW_W-1:0];
        CFG_FRAME_LAG:   frame_lag_r   <= cfg_wdata[LAGC_W-1:0];
        CFG_BAND_COUNT:  band_count_r  <= cfg_wdata[BCC_W-1:0];
        default: ;
      endcase
    end
  end

  // sample position, warm-up count and ring slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r         <= '0;
      frames_seen_r <= '0;
      wslot_r       <= '0;
    end else if (in_acc) begin
      if (last_sample) begin
        bin_r   <= '0;
        wslot_r <= (wslot_r == SLOT_W'(NSLOT - 1)) ? '0 : wslot_r + 1'b1;
        if (frames_seen_r < lag_eff) begin
          frames_seen_r <= frames_seen_r + 1'b1;
        end else begin
          frames_seen_r <= lag_eff;
        end
      end else begin
        bin_r <= bin_r + 1'b1;
      end
    end
  end

  // walk sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && last_sample) begin
          state_nxt = ((frames_seen_r < lag_eff) || no_inner) ? ST_DONE : ST_INIT;
        end
      end
      ST_INIT: begin
        ctl.clr   = 1'b1;
        state_nxt = ST_WIN;
      end
      ST_WIN: begin
        if (cnt_r == win_len) begin
          state_nxt = ST_SUM;
        end else begin
          ctl.step = 1'b1;
        end
      end
      ST_SUM: begin
        if (cnt_r == inner_r) begin
          state_nxt = ST_DIVGO;
        end else begin
          ctl.shift = 1'b1;
        end
      end
      ST_DIVGO: begin
        div_start = 1'b1;
        state_nxt = ST_DIVWAIT;
      end
      ST_DIVWAIT: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= (state_r == ST_SUM) && (cnt_r != inner_r);
      case (state_r)
        ST_INIT: cnt_r <= '0;
        ST_WIN:  cnt_r <= (cnt_r == win_len) ? '0 : cnt_r + 1'b1;
        ST_SUM:  cnt_r <= cnt_r + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc && last_sample) begin
      warm_r     <= frames_seen_r < lag_eff;
      ref_slot_r <= ref_slot;
      hw_r       <= half_window_r;
      inner_r    <= CNT_W'(32'(bc_eff) - two_hw);
      res_r      <= '0;
    end
    if (state_r == ST_INIT) begin
      sum_r <= '0;
    end else if (pvld_r) begin
      sum_r <= sum_r + $signed(SUM_W'(rd_data)) - $signed(SUM_W'(m_d_r));
    end
    m_d_r <= m_q[0];
    if (div_done) begin
      res_r <= div_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (state_r == ST_DONE && (!out_vld_r || out_tready)) begin
      out_vld_r <= 1'b1;
    end else if (out_acc) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_vld_r || out_tready)) begin
      out_diff_r <= res_r;
      out_warm_r <= warm_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TW'(unsigned'(out_diff_r));
  assign out_tuser  = out_warm_r;

  // cell row holding the current frame
  for (genvar i = 0; i < MAX_BANDS; i++) begin : g_cell
    sample_t s_nb, m_nb;
    if (i == MAX_BANDS - 1) begin : g_end
      assign s_nb = '0;
      assign m_nb = '0;
    end else begin : g_mid
      assign s_nb = s_q[i+1];
      assign m_nb = m_q[i+1];
    end
    dsd_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .wr_en   (in_acc && (bin_r == BIN_W'(i))),
      .wr_data (in_tdata[SAMPLE_BITS-1:0]),
      .s_next  (s_nb),
      .m_next  (m_nb),
      .s_q     (s_q[i]),
      .m_q     (m_q[i])
    );
  end

  // frame ring: the current frame is written as it arrives
  assign wr_addr = ADDR_W'(ADDR_W'(wslot_r) * ADDR_W'(MAX_BANDS) + ADDR_W'(bin_r));
  assign rd_addr = ADDR_W'(ADDR_W'(ref_slot_r) * ADDR_W'(MAX_BANDS)
                           + ADDR_W'(hw_r) + ADDR_W'(cnt_r));

  dsd_ram #(.DEPTH(DEPTH), .WIDTH(SAMPLE_BITS)) u_ram (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wr_addr),
    .wr_data (in_tdata[SAMPLE_BITS-1:0]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dsd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (inner_r),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

>>> sv/dsd_cell.sv
// One bin cell: holds a sample and a running window maximum.
`timescale 1ns / 1ps
module dsd_cell (
  input  logic              clk,
  input  dsd_pkg::cell_ctl_t ctl,
  input  logic              wr_en,
  input  dsd_pkg::sample_t  wr_data,
  input  dsd_pkg::sample_t  s_next,
  input  dsd_pkg::sample_t  m_next,
  output dsd_pkg::sample_t  s_q,
  output dsd_pkg::sample_t  m_q
);
  import dsd_pkg::*;

  sample_t s_r, m_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      s_r <= wr_data;
    end else if (ctl.step) begin
      s_r <= s_next;
    end
    if (ctl.clr) begin
      m_r <= '0;
    end else if (ctl.step) begin
      m_r <= smax(m_r, s_r);
    end else if (ctl.shift) begin
      m_r <= m_next;
    end
  end

  assign s_q = s_r;
  assign m_q = m_r;

endmodule

>>> sv/dsd_ram.sv
// Simple dual-port RAM, registered read.
`timescale 1ns / 1ps
module dsd_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/dsd_div.sv
// Restoring divider, one quotient bit a cycle, truncates toward zero.
`timescale 1ns / 1ps
module dsd_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [dsd_pkg::SUM_W-1:0] dividend,
  input  logic [dsd_pkg::CNT_W-1:0]      divisor,
  output logic                           done,
  output logic signed [dsd_pkg::OUT_W-1:0] quotient
);
  import dsd_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r, done_r, neg_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W:0]    rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W:0]    rem_sh;
  logic              fits;
  logic [SUM_W-1:0]  quo_signed;

  assign rem_sh = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      quo_r <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient   = quo_signed[OUT_W-1:0];
  assign done       = done_r;

endmodule

>>> sv/dsd_chk.sv
// Port-level checker for the spectral difference core, with its bind.
`timescale 1ns / 1ps
`include "dilated_spectral_difference_core_assert.svh"
module dsd_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [dsd_pkg::OUT_TW-1:0] out_tdata,
  input logic [0:0]                 out_tuser
);
  import dsd_pkg::*;

  logic            out_stall;
  logic            out_take;
  logic            out_warm;
  logic [OUT_TW:0] out_bus;

  assign out_stall = out_tvalid && !out_tready;
  assign out_take  = out_tvalid && out_tready;
  assign out_warm  = out_tvalid && out_tuser[0];
  assign out_bus   = {out_tuser, out_tdata};

  `DSD_ASSERT_NXT_RST(a_rst_quiet, clk, !rst_n, !out_tvalid, "result valid after reset")
  `DSD_ASSERT_IMP(a_warm_zero, clk, rst_n, out_warm, out_tdata == '0, "warming result not zero")
  `DSD_ASSERT_NXT(a_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_bus), "stalled result changed")
  `DSD_ASSERT_NXT(a_gap, clk, rst_n, out_take, !out_tvalid, "results back to back")

endmodule

bind dilated_spectral_difference_core dsd_chk u_chk (.*);

>>> tb/tb_dilated_spectral_difference_core.sv
// Self-checking testbench for the dilated spectral difference core.
`timescale 1ns / 1ps
module tb_dilated_spectral_difference_core;
  import dsd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 300;   // worst frame-end walk with half_window 127

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TW-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_wen;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  dilated_spectral_difference_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state: shadow registers, frame being loaded and ring of past frames
  logic [HW_W-1:0]   hw_reg;
  logic [LAGC_W-1:0] lag_reg;
  logic [BCC_W-1:0]  bc_reg;
  sample_t           cur_bins [MAX_BANDS];
  sample_t           past_bins [MAX_LAG][MAX_BANDS];
  int                bin_pos;
  int                seen_frames;
  int                ring_slot;

  // Expected frame results, oldest first
  logic signed [OUT_W-1:0] mean_q [$];
  logic                    warm_q [$];

  sample_t band_q [$];     // samples waiting to be offered
  int      gap_left;
  bit      send_idle;      // sender gaps enabled for this phase
  bit      recv_idle;      // receiver stalls enabled for this phase
  int      hold_left;      // long receiver hold-off, counted down by the receiver
  int      rdy_gap;
  bit      in_fire;
  bit      out_fire;

  int      errors;
  int      frames_done;
  int      samples_sent;
  int      warm_frames;
  longint  cycles;

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return sample_t'($urandom_range(0, 255));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Golden behaviour of one accepted band sample
  task automatic predict_band(input sample_t smp);
    int bc, lag, hw, inner, src, refv;
    longint acc;
    sample_t mx;
    logic warm;
    logic signed [OUT_W-1:0] mean;
    bc  = (bc_reg == 0) ? 1 : ((bc_reg > MAX_BANDS) ? MAX_BANDS : int'(bc_reg));
    lag = (lag_reg > MAX_LAG) ? MAX_LAG : int'(lag_reg);
    hw  = int'(hw_reg);
    cur_bins[bin_pos] = smp;
    if (bin_pos + 1 < bc) begin
      bin_pos++;
      return;
    end
    bin_pos = 0;
    warm = (seen_frames < lag);
    mean = '0;
    if (!warm && 2 * hw < bc) begin
      inner = bc - 2 * hw;
      src = (lag == 0) ? 0 : (ring_slot + MAX_LAG - lag) % MAX_LAG;
      acc = 0;
      for (int j = hw; j + hw < bc; j++) begin
        mx = '0;
        for (int k = j - hw; k < j + hw; k++)
          if (cur_bins[k] > mx) mx = cur_bins[k];
        refv = (lag == 0) ? int'(cur_bins[j]) : int'(past_bins[src][j]);
        acc += longint'(refv) - longint'(mx);
      end
      mean = OUT_W'(acc / longint'(inner));   // truncates toward zero
    end
    past_bins[ring_slot] = cur_bins;
    ring_slot = (ring_slot + 1) % MAX_LAG;
    if (seen_frames < lag) seen_frames++;
    else seen_frames = lag;
    mean_q.push_back(mean);
    warm_q.push_back(warm);
  endtask

  // Sampling at the rising edge: acceptance, prediction and checking
  always @(posedge clk) begin
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (in_fire) begin
      predict_band(sample_t'(in_tdata[SAMPLE_BITS-1:0]));
      samples_sent++;
    end
    if (out_fire) begin
      if (mean_q.size() == 0) begin
        errors++;
        $error("result transaction with no expectation: frame_mean_diff %0d warming %0b",
               $signed(out_tdata[OUT_W-1:0]), out_tuser[0]);
      end else begin
        if (out_tdata[OUT_W-1:0] !== mean_q[0]) begin
          errors++;
          $error("frame_mean_diff: expected %0d, got %0d",
                 mean_q[0], $signed(out_tdata[OUT_W-1:0]));
        end
        if (out_tuser[0] !== warm_q[0]) begin
          errors++;
          $error("warming: expected %0b, got %0b", warm_q[0], out_tuser[0]);
        end
        if (warm_q[0]) warm_frames++;
        void'(mean_q.pop_front());
        void'(warm_q.pop_front());
        frames_done++;
      end
    end
  end

  // Sender: holds the current transaction until taken, then waits its drawn gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (band_q.size() > 0) begin
        in_tdata  <= IN_TW'(band_q.pop_front());
        in_tvalid <= 1'b1;
        gap_left  <= send_idle ? $urandom_range(0, 16) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls per result, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rdy_gap    <= 0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rdy_gap > 0) begin
      rdy_gap    <= rdy_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_fire) rdy_gap <= recv_idle ? $urandom_range(0, 16) : 0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, mean_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Register write; only issued while the core is idle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    case (idx)
      CFG_HALF_WINDOW: hw_reg  = HW_W'(val);
      CFG_FRAME_LAG:   lag_reg = LAGC_W'(val);
      CFG_BAND_COUNT:  bc_reg  = BCC_W'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic drain();
    wait (band_q.size() == 0 && !in_tvalid && mean_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One phase: whole frames under one setting, so every frame boundary is clean
  task automatic run_phase(input int hw, input int lag, input int bc, input int nframes);
    int eff;
    write_reg(CFG_HALF_WINDOW, hw);
    write_reg(CFG_FRAME_LAG, lag);
    write_reg(CFG_BAND_COUNT, bc);
    eff = (bc == 0) ? 1 : bc;
    repeat (nframes * eff) band_q.push_back(pick_sample());
    drain();
  endtask

  initial begin
    int bc_cap, bc, hw, lag, nf;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0;
    out_tready = 1'b0;
    cfg_wen = 1'b0; cfg_index = '0; cfg_wdata = '0;
    hw_reg = 7'd1; lag_reg = 4'd1; bc_reg = 9'd256;
    bin_pos = 0; seen_frames = 0; ring_slot = 0;
    gap_left = 0; hold_left = 0;
    send_idle = 1'b1; recv_idle = 1'b1;
    errors = 0; frames_done = 0; samples_sent = 0; warm_frames = 0; cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: three frames of band count 8 under reset half window and lag: all-ones, all-zero, random
    bc_reg = 9'd8;
    write_reg(CFG_BAND_COUNT, 8);
    repeat (8) band_q.push_back('1);
    repeat (8) band_q.push_back('0);
    repeat (8) band_q.push_back(sample_t'($urandom));
    drain();

    // Full band count with lag zero: the frame is compared with itself, widest window
    run_phase(127, 0, 256, 1);

    // Past frames read with a lag must have been at least as long, so band counts
    // only ever fall from here on. Lag zero phases follow the same rule.
    bc_cap = 4;
    run_phase(0, 8, bc_cap, 10);       // empty window, deepest lag after warm-up
    run_phase(2, 3, bc_cap, 3);        // half window at its limit, no inner bins

    // Back-pressure: receiver holds off while many frames are queued behind it
    hold_left = 400;
    send_idle = 1'b0;
    run_phase(1, 15, 3, 14);           // lag above range acts as the deepest lag
    send_idle = 1'b1;
    bc_cap = 3;

    for (int p = 0; p < 24 && samples_sent < 390; p++) begin
      bc = $urandom_range((bc_cap > 3) ? bc_cap - 1 : 1, bc_cap);
      bc_cap = bc;
      hw  = ($urandom_range(0, 7) == 0) ? 127 : $urandom_range(0, bc / 2);
      lag = $urandom_range(0, 15);
      nf  = $urandom_range(4, 12);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      run_phase(hw, lag, bc, nf);
    end

    // Smallest frames: one band and a band count of zero acting as one
    send_idle = 1'b1; recv_idle = 1'b1;
    for (int p = 0; p < 3; p++)
      run_phase($urandom_range(0, 1), $urandom_range(0, 8), 1, 8);
    run_phase(0, 2, 0, 10);
    send_idle = 1'b0; recv_idle = 1'b0;
    run_phase(0, 0, 1, 10);

    $display("%0d band samples sent, %0d frame results checked (%0d warming)",
             samples_sent, frames_done, warm_frames);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> dilated_spectral_difference_core.f
+incdir+sv
sv/dsd_pkg.sv
sv/dsd_cell.sv
sv/dsd_ram.sv
sv/dsd_div.sv
sv/dilated_spectral_difference_core.sv
sv/dsd_chk.sv
tb/tb_dilated_spectral_difference_core.sv
